// ===== rtl/bgc_pkg.sv =====
`timescale 1ns / 1ps

package bgc_pkg;

   localparam int CFG_W       = 20;
   localparam int GESTURE_W   = 3;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Gesture codes
   localparam logic [GESTURE_W-1:0] GEST_SINGLE    = 3'd0;
   localparam logic [GESTURE_W-1:0] GEST_DOUBLE    = 3'd1;
   localparam logic [GESTURE_W-1:0] GEST_LONG      = 3'd2;
   localparam logic [GESTURE_W-1:0] GEST_VERY_LONG = 3'd3;
   localparam logic [GESTURE_W-1:0] GEST_UNKNOWN   = 3'd4;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_SHORT_LIMIT = 2'd0;
   localparam logic [1:0] REG_LONG_LOW    = 2'd1;
   localparam logic [1:0] REG_LONG_HIGH   = 2'd2;
   localparam logic [1:0] REG_WINDOW      = 2'd3;

   localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = 20'd1000;
   localparam logic [CFG_W-1:0] LONG_LOW_RST    = 20'd3000;
   localparam logic [CFG_W-1:0] LONG_HIGH_RST   = 20'd8000;
   localparam logic [CFG_W-1:0] WINDOW_RST      = 20'd500;

   typedef struct packed {
      logic [CFG_W-1:0] short_limit_ms;
      logic [CFG_W-1:0] long_low_ms;
      logic [CFG_W-1:0] long_high_ms;
      logic [CFG_W-1:0] window_ms;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [GESTURE_W-1:0] gesture;
      logic [CFG_W-1:0]     first_duration_ms;
   } res_type;

endpackage

// ===== rtl/bgc_core.sv =====
`timescale 1ns / 1ps

module bgc_core #(
   parameter int TIMER_WIDTH = 20
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            tick_valid,
   input  logic            pin_level,
   input  bgc_pkg::cfg_type cfg,
   output bgc_pkg::res_type res
);
   import bgc_pkg::*;

   localparam int TW = TIMER_WIDTH;
   localparam int CW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HELD = 2'd1;
   localparam logic [1:0] PH_WAIT = 2'd2;

   localparam logic [TW-1:0] T_ONE  = TW'(1);
   localparam logic [CW-1:0] OUT_MAX = CW'({CFG_W{1'b1}});

   logic [1:0]    phase_ff,  phase_in;
   logic [TW-1:0] press_ff,  press_in;
   logic [TW-1:0] win_ff,    win_in;
   logic [TW-1:0] d0_ff,     d0_in;
   logic [TW-1:0] d1_ff,     d1_in;
   logic [1:0]    count_ff,  count_in;

   logic          pressed;
   logic [TW-1:0] win_inc;
   logic          win_done;
   logic          emit;
   logic [CW-1:0] d0_x, d1_x;
   logic [GESTURE_W-1:0] gesture;

   function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
      return (&v) ? v : v + T_ONE;
   endfunction

   assign pressed  = ~pin_level;
   assign win_inc  = sat_inc(win_ff);
   assign win_done = CW'(win_inc) >= CW'(cfg.window_ms);

   always_comb begin
      phase_in = phase_ff;
      press_in = press_ff;
      win_in   = win_ff;
      d0_in    = d0_ff;
      d1_in    = d1_ff;
      count_in = count_ff;
      emit     = 1'b0;
      unique case (phase_ff)
         PH_HELD: begin
            win_in = win_inc;
            if (pressed) begin
               press_in = sat_inc(press_ff);
            end else begin
               if (count_ff == 2'd0) d0_in = press_ff;
               if (count_ff == 2'd1) d1_in = press_ff;
               if (count_ff != 2'd3) count_in = count_ff + 2'd1;
               phase_in = PH_WAIT;
               emit     = win_done;
            end
         end
         PH_WAIT: begin
            win_in = win_inc;
            emit   = win_done;
            if (pressed) begin
               phase_in = PH_HELD;
               press_in = T_ONE;
               win_in   = T_ONE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (pressed) begin
               phase_in = PH_HELD;
               press_in = T_ONE;
               win_in   = T_ONE;
            end
         end
      endcase
   end

   // Classify from the durations as they stand after this tick's store
   assign d0_x = CW'(d0_in);
   assign d1_x = CW'(d1_in);

   always_comb begin
      if (d0_x < CW'(cfg.short_limit_ms) && count_in == 2'd1)
         gesture = GEST_SINGLE;
      else if (d0_x < CW'(cfg.short_limit_ms) && count_in >= 2'd2
               && d1_x < CW'(cfg.short_limit_ms))
         gesture = GEST_DOUBLE;
      else if (d0_x >= CW'(cfg.long_low_ms) && d0_x < CW'(cfg.long_high_ms))
         gesture = GEST_LONG;
      else if (d0_x > CW'(cfg.long_high_ms))
         gesture = GEST_VERY_LONG;
      else
         gesture = GEST_UNKNOWN;
   end

   always_comb begin
      res.valid             = tick_valid & emit;
      res.gesture           = gesture;
      res.first_duration_ms = (d0_x > OUT_MAX) ? {CFG_W{1'b1}} : CFG_W'(d0_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         press_ff <= '0;
         win_ff   <= '0;
         d0_ff    <= '0;
         d1_ff    <= '0;
         count_ff <= '0;
      end else if (tick_valid) begin
         if (emit) begin
            // Clear the sequence, then start a new one on a press
            phase_ff <= pressed ? PH_HELD : PH_IDLE;
            press_ff <= pressed ? T_ONE : '0;
            win_ff   <= pressed ? T_ONE : '0;
            d0_ff    <= '0;
            d1_ff    <= '0;
            count_ff <= '0;
         end else begin
            phase_ff <= phase_in;
            press_ff <= press_in;
            win_ff   <= win_in;
            d0_ff    <= d0_in;
            d1_ff    <= d1_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

// ===== rtl/button_gesture_classifier.sv =====
`timescale 1ns / 1ps

// Button gesture classifier.
// Feed one request per millisecond tick on req_*: req_tdata[0] is the sampled
// button pin, active low. Each press is timed by a saturating counter; after
// a release, once the follow-up window (counted from the last press start)
// has run out, one result leaves on rsp_*: gesture code and first press time.
// Registers sit on an APB-style port at 0x0 short limit, 0x4 long low,
// 0x8 long high, 0xC window; write them only while no tick is in flight.
// A result enters the main result register (or the skid entry, if that one is
// held) as its tick is accepted. Throughput: one request per cycle; the whole
// tick update is one short combinational pass from the state registers into
// the result register, so nothing limits the rate but the output buffer.
// Stall: a main result register plus one skid entry; req_tready drops only
// when both hold results, and comes back once the receiver takes one.
// Reset: synchronous, clears the tick state and the result buffer, and loads
// the register defaults (1000, 3000, 8000, 500 ms). No clearing pass.
module button_gesture_classifier #(
   parameter int TIMER_WIDTH = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bgc_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [0] pin_level, [7:1] zero
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bgc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // [2:0] gesture,
                                                           // [22:3] first_duration_ms,
                                                           // [23] zero
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bgc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bgc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bgc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import bgc_pkg::*;

   cfg_type cfg_ff;
   res_type res;

   logic [RSP_TDATA_W-1:0] main_data_ff, main_data_in;
   logic [RSP_TDATA_W-1:0] skid_data_ff, skid_data_in;
   logic                   main_valid_ff, main_valid_in;
   logic                   skid_valid_ff, skid_valid_in;

   logic                   accept;
   logic                   push;
   logic                   pop;
   logic [1:0]             reg_index;
   logic                   csr_write;
   logic [RSP_TDATA_W-1:0] new_data;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_limit_ms <= SHORT_LIMIT_RST;
         cfg_ff.long_low_ms    <= LONG_LOW_RST;
         cfg_ff.long_high_ms   <= LONG_HIGH_RST;
         cfg_ff.window_ms      <= WINDOW_RST;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_SHORT_LIMIT: cfg_ff.short_limit_ms <= csr_pwdata[CFG_W-1:0];
            REG_LONG_LOW:    cfg_ff.long_low_ms    <= csr_pwdata[CFG_W-1:0];
            REG_LONG_HIGH:   cfg_ff.long_high_ms   <= csr_pwdata[CFG_W-1:0];
            REG_WINDOW:      cfg_ff.window_ms      <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register, zero-extended
   always_comb begin
      unique case (reg_index)
         REG_SHORT_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.short_limit_ms);
         REG_LONG_LOW:    csr_prdata = CSR_DATA_W'(cfg_ff.long_low_ms);
         REG_LONG_HIGH:   csr_prdata = CSR_DATA_W'(cfg_ff.long_high_ms);
         REG_WINDOW:      csr_prdata = CSR_DATA_W'(cfg_ff.window_ms);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- tick processing ----------------
   // Take a tick whenever the skid entry is free; the state advances on accept
   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;

   bgc_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .tick_valid (accept),
      .pin_level  (req_tdata[0]),
      .cfg        (cfg_ff),
      .res        (res)
   );

   assign new_data = {1'b0, res.first_duration_ms, res.gesture};
   assign push     = res.valid;
   assign pop      = main_valid_ff & rsp_tready;

   // ---------------- result buffer: main register plus skid ----------------
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            // Advance the skid entry; no push can arrive while it is full
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_data_in  = new_data;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = new_data;
         end else begin
            // Hold the main result; park the new one
            skid_valid_in = 1'b1;
            skid_data_in  = new_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_data_ff;

endmodule

// ===== rtl/bgc_checker.sv =====
`timescale 1ns / 1ps

module bgc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bgc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            csr_pready
);
   import bgc_pkg::*;

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // Results come out of a cleared buffer only after reset ends
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // Only the five gesture codes leave, with the pad bit clear
   a_gesture_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[GESTURE_W-1:0] == GEST_SINGLE ||
                      rsp_tdata[GESTURE_W-1:0] == GEST_DOUBLE ||
                      rsp_tdata[GESTURE_W-1:0] == GEST_LONG ||
                      rsp_tdata[GESTURE_W-1:0] == GEST_VERY_LONG ||
                      rsp_tdata[GESTURE_W-1:0] == GEST_UNKNOWN) &&
                     !rsp_tdata[RSP_TDATA_W-1])
      else $error("bad gesture code on result");

   // Register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr_pready low");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

// ===== sim/button_gesture_classifier_tb.sv =====
`timescale 1ns / 1ps

module button_gesture_classifier_tb;
   import bgc_pkg::*;

   localparam int TIMER_W = 20;

   // Tracking phase of the press sequence inside the predictor
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HELD,
      PH_WAIT
   } press_phase_type;

   typedef struct packed {
      logic [GESTURE_W-1:0] gesture;
      logic [CFG_W-1:0]     first_ms;
   } gesture_rec_type;

   // Gesture predictor plus the queue of gestures still owed by the block
   class gesture_scoreboard;
      logic [CFG_W-1:0]   short_limit;
      logic [CFG_W-1:0]   long_low;
      logic [CFG_W-1:0]   long_high;
      logic [CFG_W-1:0]   window_len;
      press_phase_type    phase;
      logic [TIMER_W-1:0] press_timer;
      logic [TIMER_W-1:0] window_timer;
      logic [TIMER_W-1:0] first_dur;
      logic [TIMER_W-1:0] second_dur;
      logic [1:0]         press_count;
      gesture_rec_type    gestures_due[$];
      int                 mismatches;
      int                 gestures_seen;
      int                 gesture_hist[5];

      function void clear_sequence();
         phase        = PH_IDLE;
         press_timer  = '0;
         window_timer = '0;
         first_dur    = '0;
         second_dur   = '0;
         press_count  = '0;
      endfunction

      function void reset_all();
         short_limit = SHORT_LIMIT_RST;
         long_low    = LONG_LOW_RST;
         long_high   = LONG_HIGH_RST;
         window_len  = WINDOW_RST;
         clear_sequence();
      endfunction

      function void set_limit(input logic [1:0] idx, input logic [CFG_W-1:0] value);
         case (idx)
            REG_SHORT_LIMIT: short_limit = value;
            REG_LONG_LOW:    long_low    = value;
            REG_LONG_HIGH:   long_high   = value;
            REG_WINDOW:      window_len  = value;
            default: ;
         endcase
      endfunction

      function logic [TIMER_W-1:0] sat_up(input logic [TIMER_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      function void start_press();
         phase        = PH_HELD;
         press_timer  = TIMER_W'(1);
         window_timer = TIMER_W'(1);
      endfunction

      // Classify on the first rule that matches, queue it, drop the sequence
      function void close_sequence();
         gesture_rec_type rec;
         if (first_dur < short_limit && press_count == 2'd1)
            rec.gesture = GEST_SINGLE;
         else if (first_dur < short_limit && press_count >= 2'd2 && second_dur < short_limit)
            rec.gesture = GEST_DOUBLE;
         else if (first_dur >= long_low && first_dur < long_high)
            rec.gesture = GEST_LONG;
         else if (first_dur > long_high)
            rec.gesture = GEST_VERY_LONG;
         else
            rec.gesture = GEST_UNKNOWN;
         rec.first_ms = first_dur;
         gestures_due.push_back(rec);
         clear_sequence();
      endfunction

      function void take_tick(input logic pin);
         logic pressed;
         pressed = !pin;
         case (phase)
            PH_HELD: begin
               window_timer = sat_up(window_timer);
               if (pressed) begin
                  press_timer = sat_up(press_timer);
               end else begin
                  if (press_count == 2'd0)
                     first_dur = press_timer;
                  else if (press_count == 2'd1)
                     second_dur = press_timer;
                  if (press_count < 2'd3)
                     press_count = press_count + 1'b1;
                  phase = PH_WAIT;
                  if (window_timer >= window_len)
                     close_sequence();
               end
            end
            PH_WAIT: begin
               window_timer = sat_up(window_timer);
               if (window_timer >= window_len) begin
                  close_sequence();
                  if (pressed)
                     start_press();
               end else if (pressed) begin
                  start_press();
               end
            end
            default: begin
               phase = PH_IDLE;
               if (pressed)
                  start_press();
            end
         endcase
      endfunction

      function void check_gesture(input logic [RSP_TDATA_W-1:0] tdata);
         gesture_rec_type want;
         if (gestures_due.size() == 0) begin
            $display("%0t: unexpected gesture %0d first %0d ms (nothing pending)",
                     $time, tdata[2:0], tdata[22:3]);
            mismatches++;
            return;
         end
         want = gestures_due.pop_front();
         gestures_seen++;
         if (tdata[2:0] !== want.gesture) begin
            $display("%0t: gesture mismatch, expected %0d, actual %0d",
                     $time, want.gesture, tdata[2:0]);
            mismatches++;
         end
         if (tdata[22:3] !== want.first_ms) begin
            $display("%0t: first_duration_ms mismatch, expected %0d, actual %0d",
                     $time, want.first_ms, tdata[22:3]);
            mismatches++;
         end
         if (tdata[23] !== 1'b0) begin
            $display("%0t: pad bit mismatch, expected 0, actual %b", $time, tdata[23]);
            mismatches++;
         end
         if (want.gesture <= GEST_UNKNOWN)
            gesture_hist[want.gesture]++;
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // [0] pin_level, [7:1] zero
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [2:0] gesture, [22:3] first_duration_ms, [23] zero
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   gesture_scoreboard sb;
   bit                steady;          // suppress random idling on both sides
   int                hold_off_cycles; // receiver stall requested by the stimulus
   int                ticks_sent;
   int                phases_run;

   button_gesture_classifier #(
      .TIMER_WIDTH(TIMER_W)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Give up long after the slowest legal run would have finished
   initial begin
      #(64'd2_000_000 * 12);
      $display("%0t: timeout, %0d gestures still pending", $time, sb.gestures_due.size());
      $display("** button_gesture_classifier: FAILED **");
      $finish;
   end

   // Receiver: take results at the rising edge, pick tready at the falling edge.
   // A requested hold-off is counted down here, one cycle at a time.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_gesture(rsp_tdata);
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= 6);
         end
      end
   end

   // Offer one tick request; enter and leave at a falling edge, keep tvalid high
   // on return so back-to-back requests need no second assignment per step.
   task automatic send_tick(input logic pin);
      while (!steady && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {7'b0, 1'($urandom)};
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, pin};
      do @(posedge clock); while (!req_tready);
      sb.take_tick(pin);
      ticks_sent++;
      @(negedge clock);
   endtask

   // Hold the button for some ticks, then release it for some ticks
   task automatic press_release(input int held, input int released);
      repeat (held) send_tick(1'b0);
      repeat (released) send_tick(1'b1);
   endtask

   // Release until the open sequence has been classified
   task automatic settle();
      while (sb.phase != PH_IDLE)
         send_tick(1'b1);
   endtask

   // Stop offering, wait for every owed gesture, then let the block go quiet
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.gestures_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register (setup then access cycle), then read it back
   task automatic csr_write(input logic [1:0] idx, input logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {{(CSR_DATA_W-CFG_W){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_limit(idx, value);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      if (readback[CFG_W-1:0] !== value) begin
         $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
                  $time, idx, value, readback[CFG_W-1:0]);
         sb.mismatches++;
      end
   endtask

   task automatic load_limits(input logic [CFG_W-1:0] short_ms, input logic [CFG_W-1:0] low_ms,
                              input logic [CFG_W-1:0] high_ms, input logic [CFG_W-1:0] win_ms);
      csr_write(REG_SHORT_LIMIT, short_ms);
      csr_write(REG_LONG_LOW, low_ms);
      csr_write(REG_LONG_HIGH, high_ms);
      csr_write(REG_WINDOW, win_ms);
      phases_run++;
   endtask

   // One well-formed press sequence with random press and gap lengths
   task automatic random_sequence();
      int presses;
      int held;
      int gap;
      presses = $urandom_range(1, 4);
      for (int p = 0; p < presses; p++) begin
         if ($urandom_range(1))
            held = $urandom_range(1, int'(sb.short_limit) + 1);
         else
            held = $urandom_range(1, int'(sb.long_high) + 3);
         gap = (p == presses - 1) ? 0 : $urandom_range(1, int'(sb.window_len) + 3);
         press_release(held, gap);
      end
      settle();
      repeat ($urandom_range(0, 4)) send_tick(1'b1);
   endtask

   initial begin
      int phase_start;

      // Drive every input to a known level before the first edge
      clock           = 1'b0;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      steady          = 1'b0;
      hold_off_cycles = 0;
      ticks_sent      = 0;
      phases_run      = 1;
      sb = new();
      sb.reset_all();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Defaults after reset: one plain click
      press_release(20, 1);
      settle();
      wait_idle();

      // Small limits: every gesture kind and the corner cases
      load_limits(20'd8, 20'd12, 20'd20, 20'd16);
      press_release(3, 1);   settle();                 // single
      press_release(3, 4);   press_release(3, 1);  settle();  // double
      repeat (4) press_release(2, 2);  settle();       // fourth press keeps count saturated
      press_release(15, 1);  settle();                 // long
      press_release(25, 1);  settle();                 // very long
      press_release(20, 1);  settle();                 // at long upper bound: unclassified
      press_release(10, 1);  settle();                 // between click and long: unclassified
      press_release(8, 1);   settle();                 // exactly the click limit
      press_release(3, 3);   press_release(10, 1); settle();  // second press too long
      press_release(3, 12);  press_release(3, 1);  settle();  // press on the expiry tick
      press_release(1, 1);   settle();                 // one-tick bounce
      wait_idle();

      // Extremes: everything is a click, window zero closes on the release tick
      load_limits(20'hFFFFF, 20'd1, 20'hFFFFF, 20'd0);
      press_release(1, 1);
      press_release(5, 2);
      press_release(2, 1);
      settle();
      wait_idle();

      // Opposite extremes: nothing is a click, long band is empty
      load_limits(20'd1, 20'hFFFFF, 20'd1, 20'd1);
      press_release(1, 1);
      press_release(2, 1);
      press_release(3, 3);
      settle();
      wait_idle();

      // Back-pressure: receiver holds off while one-tick clicks pile up results,
      // so the result buffer fills and the request side stalls
      load_limits(20'd4, 20'd5, 20'd9, 20'd1);
      hold_off_cycles = 300;
      repeat (30) press_release(1, 1);
      settle();
      wait_idle();

      // Random phases; the first one runs with no idling at all
      steady = 1'b1;
      while (ticks_sent < 1050) begin
         load_limits(20'($urandom_range(1, 14)), 20'($urandom_range(1, 24)),
                     20'($urandom_range(1, 30)), 20'($urandom_range(0, 24)));
         phase_start = ticks_sent;
         while (ticks_sent - phase_start < 60) begin
            if ($urandom_range(99) < 85) begin
               random_sequence();
            end else begin
               repeat ($urandom_range(1, 20)) send_tick(1'($urandom));
            end
         end
         settle();
         wait_idle();
         steady = 1'b0;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.gestures_due.size() != 0) begin
         $display("%0t: %0d expected gestures never arrived", $time, sb.gestures_due.size());
         sb.mismatches++;
      end

      $display("Sent %0d ticks over %0d limit settings, %0d gestures checked", ticks_sent,
               phases_run, sb.gestures_seen);
      $display("Mix single/double/long/very long/unclassified: %0d/%0d/%0d/%0d/%0d",
               sb.gesture_hist[0], sb.gesture_hist[1], sb.gesture_hist[2],
               sb.gesture_hist[3], sb.gesture_hist[4]);
      if (sb.mismatches == 0) begin
         $display("** button_gesture_classifier: PASSED **");
      end else begin
         $display("** button_gesture_classifier: FAILED **");
      end
      $finish;
   end

endmodule
